// ===== rtl/fat32dem_pkg.sv =====
// ----------------------------------------------------------------------------
// fat32dem_pkg
// Types, codes and constants shared by the directory entry matcher.
// ----------------------------------------------------------------------------
package fat32dem_pkg;

    localparam int unsigned ENTRY_BYTES = 32;
    localparam int unsigned NAME_BYTES  = 11;
    localparam int unsigned OFF_W       = $clog2(ENTRY_BYTES);

    // entry byte offsets
    localparam logic [OFF_W-1:0] OFF_FIRST   = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFF_ATTR    = OFF_W'(NAME_BYTES);
    localparam logic [OFF_W-1:0] OFF_CLU_HI0 = OFF_W'(20);
    localparam logic [OFF_W-1:0] OFF_CLU_HI1 = OFF_W'(21);
    localparam logic [OFF_W-1:0] OFF_CLU_LO0 = OFF_W'(26);
    localparam logic [OFF_W-1:0] OFF_CLU_LO1 = OFF_W'(27);
    localparam logic [OFF_W-1:0] OFF_SIZE0   = OFF_W'(28);
    localparam logic [OFF_W-1:0] OFF_SIZE1   = OFF_W'(29);
    localparam logic [OFF_W-1:0] OFF_SIZE2   = OFF_W'(30);
    localparam logic [OFF_W-1:0] OFF_LAST    = OFF_W'(ENTRY_BYTES - 1);

    // marker and attribute values
    localparam logic [7:0] MARK_END     = 8'h00;
    localparam logic [7:0] MARK_DELETED = 8'hE5;
    localparam logic [7:0] ATTR_LONG    = 8'h0F;
    localparam int unsigned ATTR_DIR_POS = 4;

    // result status codes
    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_END       = 3'd1;
    localparam logic [2:0] ST_IS_DIR    = 3'd2;
    localparam logic [2:0] ST_IS_FILE   = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NAME_EXT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WANT_DIR  = 2'd2;

    localparam logic [63:0] RST_NAME_BASE = 64'h2020_2020_2020_2020;
    localparam logic [23:0] RST_NAME_EXT  = 24'h20_2020;

    typedef struct packed {
        logic [7:0] dir_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] start_cluster;
        logic [31:0] entry_size;
    } t_out;

    typedef struct packed {
        logic [63:0] target_name_base;
        logic [23:0] target_name_ext;
        logic        want_directory;
    } t_cfg;

endpackage

// ===== rtl/fat32_directory_entry_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// fat32_directory_entry_matcher_unit
// Scans a FAT32 directory byte stream for one 8.3 short name entry.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------
//   in      | input     | i_in_valid / o_in_stall | t_in  (byte, last)
//   out     | output    | o_out_valid/ i_out_stall| t_out (status, cluster, size)
//   cfg     | input     | i_cfg_valid/ o_cfg_ready| index, 64-bit data
//
// One byte per cycle while no stall holds it; a byte is taken into the input
// register, and its result is then captured in the result register.
// Reset clears the scan state and loads a blank target name, file kind.
// A stalled result only holds back bytes that would produce a result;
// other bytes keep flowing. Config writes are always ready.
// ----------------------------------------------------------------------------
module fat32_directory_entry_matcher_unit
    import fat32dem_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    t_cfg w_cfg;
    t_in  r_in;
    logic r_in_valid;
    logic r_out_valid;
    t_out r_out;
    logic w_produce;
    t_out w_result;
    logic w_out_free;
    logic w_fire;
    logic w_accept;

    assign o_cfg_ready = 1'b1;

    fat32dem_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    fat32dem_entry_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (w_fire),
        .i_item    (r_in),
        .i_cfg     (w_cfg),
        .o_produce (w_produce),
        .o_result  (w_result)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && (w_out_free || !w_produce);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_produce) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_produce) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/fat32dem_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fat32dem_cfg_regs
// Target name and wanted kind registers behind the configuration write port.
// ----------------------------------------------------------------------------
module fat32dem_cfg_regs
    import fat32dem_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_name_base <= RST_NAME_BASE;
            r_cfg.target_name_ext  <= RST_NAME_EXT;
            r_cfg.want_directory   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NAME_BASE: r_cfg.target_name_base <= i_cfg_data;
                CFG_NAME_EXT:  r_cfg.target_name_ext  <= i_cfg_data[23:0];
                CFG_WANT_DIR:  r_cfg.want_directory   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/fat32dem_entry_scan.sv =====
// ----------------------------------------------------------------------------
// fat32dem_entry_scan
// Per-entry scan state and the decision logic for one directory byte.
// ----------------------------------------------------------------------------
module fat32dem_entry_scan
    import fat32dem_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output logic o_produce,
    output t_out o_result
);

    logic [OFF_W-1:0] r_offset, n_offset;
    logic             r_decided, n_decided;
    logic             r_name_eq, n_name_eq;
    logic [7:0]       r_first;
    logic [7:0]       r_attr;
    logic [15:0]      r_clu_hi;
    logic [15:0]      r_clu_lo;
    logic [23:0]      r_size;

    logic [127:0] w_target;
    logic [7:0]   w_tchar;
    logic [7:0]   w_byte;
    logic         w_active;
    logic         w_in_name;
    logic         w_char_eq;
    logic         w_end_hit;
    logic         w_match;
    logic         w_is_dir;

    assign w_byte   = i_item.dir_byte;
    assign w_active = !r_decided;
    assign w_target = {40'd0, i_cfg.target_name_ext, i_cfg.target_name_base};
    assign w_tchar  = w_target[{r_offset[3:0], 3'b000} +: 8];
    assign w_in_name = (r_offset < OFF_W'(NAME_BYTES));
    assign w_char_eq = (w_byte == w_tchar);

    assign w_end_hit = (r_offset == OFF_FIRST) && (w_byte == MARK_END);
    assign w_match   = (r_offset == OFF_LAST) && (r_first != MARK_DELETED)
                       && (r_attr != ATTR_LONG) && r_name_eq;
    assign w_is_dir  = r_attr[ATTR_DIR_POS];

    assign o_produce = w_active && (w_end_hit || w_match || i_item.last_byte);

    always_comb begin
        o_result = '0;
        priority if (w_end_hit) begin
            o_result.status = ST_END;
        end else if (w_match) begin
            priority if (i_cfg.want_directory && !w_is_dir) begin
                o_result.status = ST_IS_FILE;
            end else if (!i_cfg.want_directory && w_is_dir) begin
                o_result.status = ST_IS_DIR;
            end else begin
                o_result.status        = ST_FOUND;
                o_result.start_cluster = {r_clu_hi, r_clu_lo};
                o_result.entry_size    = {w_byte, r_size};
            end
        end else begin
            o_result.status = ST_EXHAUSTED;
        end
    end

    always_comb begin
        n_offset  = r_offset;
        n_decided = r_decided;
        n_name_eq = r_name_eq;
        if (i_item.last_byte) begin
            n_offset  = '0;
            n_decided = 1'b0;
            n_name_eq = 1'b1;
        end else if (w_active) begin
            n_offset  = r_offset + OFF_W'(1);
            n_decided = w_end_hit || w_match;
            // first name byte restarts the comparison
            if (r_offset == OFF_FIRST) begin
                n_name_eq = w_char_eq;
            end else if (w_in_name) begin
                n_name_eq = r_name_eq && w_char_eq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_decided <= 1'b0;
            r_name_eq <= 1'b1;
        end else if (i_fire) begin
            r_offset  <= n_offset;
            r_decided <= n_decided;
            r_name_eq <= n_name_eq;
        end
    end

    // field capture; each field is written before byte 31 reads it
    always_ff @(posedge i_clk) begin
        if (i_fire && w_active) begin
            if (r_offset == OFF_FIRST)   r_first        <= w_byte;
            if (r_offset == OFF_ATTR)    r_attr         <= w_byte;
            if (r_offset == OFF_CLU_HI0) r_clu_hi[7:0]  <= w_byte;
            if (r_offset == OFF_CLU_HI1) r_clu_hi[15:8] <= w_byte;
            if (r_offset == OFF_CLU_LO0) r_clu_lo[7:0]  <= w_byte;
            if (r_offset == OFF_CLU_LO1) r_clu_lo[15:8] <= w_byte;
            if (r_offset == OFF_SIZE0)   r_size[7:0]    <= w_byte;
            if (r_offset == OFF_SIZE1)   r_size[15:8]   <= w_byte;
            if (r_offset == OFF_SIZE2)   r_size[23:16]  <= w_byte;
        end
    end

endmodule

// ===== rtl/fat32dem_checker.sv =====
// ----------------------------------------------------------------------------
// fat32dem_checker
// Port-level checks on the directory entry matcher.
// ----------------------------------------------------------------------------
module fat32dem_checker
    import fat32dem_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out                 o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result request changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.status == ST_FOUND || o_out.status == ST_END
                         || o_out.status == ST_IS_DIR || o_out.status == ST_IS_FILE
                         || o_out.status == ST_EXHAUSTED))
        else $error("status code out of range");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_FOUND)
            |-> (o_out.start_cluster == 32'd0) && (o_out.entry_size == 32'd0))
        else $error("cluster or size nonzero without a match");

endmodule

bind fat32_directory_entry_matcher_unit fat32dem_checker u_fat32dem_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
